### hw/rtl/tbp_pkg.sv
// Shared types, constants and a saturating counter helper for the tournament branch predictor.
package tbp_pkg;

  typedef logic [1:0] ctr_t;

  localparam ctr_t CTR_MAX = 2'd3;
  localparam ctr_t CTR_MIN = 2'd0;

  localparam ctr_t BIM_RST_VAL = CTR_MAX;
  localparam ctr_t GSH_RST_VAL = CTR_MAX;
  localparam ctr_t CHO_RST_VAL = CTR_MIN;

  localparam int ADDR_W      = 32;
  localparam int HIT_W       = 32;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_FIELD_W = 3 + HIT_W;
  localparam int OUT_TDATA_W = 40;

  function automatic ctr_t sat_move(ctr_t c, logic up);
    ctr_t r;
    r = c;
    if (up) begin
      if (c != CTR_MAX) r = c + 2'd1;
    end else begin
      if (c != CTR_MIN) r = c - 2'd1;
    end
    return r;
  endfunction

endpackage

### hw/rtl/tournament_branch_predictor_core.sv
// Tournament branch predictor core: bimodal and gshare tables with a per-address chooser.
//
// The input channel carries one resolved branch per request: its address and
// its actual direction. For each request the block returns one result: the
// prediction it would have made, whether that was right, which predictor the
// chooser selected, and the running count of correct predictions.
// A request accepted at one clock edge is held in the middle stage with its counters
// read, and its result is written to the output register when that stage advances. One
// request can be accepted in every cycle while the output is not stalled; the rate is set by
// the single read-modify-write pass through the three counter memories, with the newest written
// entries forwarded to the following request. The global history shifts when a request is accepted.
// After reset the block runs a clearing pass over every table entry that
// loads every counter with its initial value; in_tready stays low during it.
// When the receiver stalls, the output register holds its result, the middle stage keeps its
// request and, once that stage is full, input acceptance stops until the output drains.
module tournament_branch_predictor_core
  import tbp_pkg::*;
#(
  parameter int TABLE_ENTRIES = 2048,
  parameter int HISTORY_BITS  = 11
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // branch_address[31:0], taken[32], zero pad
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // predicted_taken[0], prediction_correct[1],
                                             // chose_bimodal[2], correct_total[34:3], zero pad
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    idx_t bi;
    idx_t gi;
    logic taken;
    logic fwd;
  } stage_t;

  ctr_t bim_mem [TABLE_ENTRIES];
  ctr_t gsh_mem [TABLE_ENTRIES];
  ctr_t cho_mem [TABLE_ENTRIES];

  logic                    clr_busy_r;
  idx_t                    clr_idx_r;
  logic                    s1_vld_r;
  stage_t                  s1_r;
  logic [HISTORY_BITS-1:0] hist_r;
  logic [HISTORY_BITS-1:0] hist_nxt;
  logic [HIT_W-1:0]        hit_r;
  logic [HIT_W-1:0]        hit_nxt;
  logic                    out_vld_r;
  logic [OUT_TDATA_W-1:0]  out_tdata_r;

  ctr_t rd_bim_r, rd_gsh_r, rd_cho_r;
  idx_t wb_bi_r, wb_gi_r;
  ctr_t wb_bim_r, wb_gsh_r, wb_cho_r;

  logic [ADDR_W-1:0] in_addr;
  logic              in_taken;
  logic [ADDR_W-1:0] gsh_hash;
  idx_t              in_bi, in_gi;
  logic              in_acc;
  logic              s1_adv, s1_fire;

  ctr_t bim_cur, gsh_cur, cho_cur;
  ctr_t bim_new, gsh_new, cho_new;
  logic bim_dir, gsh_dir, sel_bim, final_dir, ok;

  assign in_addr  = in_tdata[ADDR_W-1:0];
  assign in_taken = in_tdata[ADDR_W];
  assign gsh_hash = in_addr ^ ADDR_W'(hist_r);
  assign in_bi    = in_addr[IDX_W-1:0];
  assign in_gi    = gsh_hash[IDX_W-1:0];
  assign hist_nxt = HISTORY_BITS'({hist_r, in_taken});

  assign s1_adv    = !out_vld_r || out_tready;
  assign s1_fire   = s1_vld_r && s1_adv;
  assign in_tready = !clr_busy_r && (!s1_vld_r || s1_adv);
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    bim_cur = (s1_r.fwd && s1_r.bi == wb_bi_r) ? wb_bim_r : rd_bim_r;
    cho_cur = (s1_r.fwd && s1_r.bi == wb_bi_r) ? wb_cho_r : rd_cho_r;
    gsh_cur = (s1_r.fwd && s1_r.gi == wb_gi_r) ? wb_gsh_r : rd_gsh_r;
    bim_dir = bim_cur[1];
    gsh_dir = gsh_cur[1];
    sel_bim = cho_cur[1];
    if (bim_dir == gsh_dir) begin
      final_dir = bim_dir;
      cho_new   = cho_cur;
    end else begin
      final_dir = sel_bim ? bim_dir : gsh_dir;
      cho_new   = sat_move(cho_cur, bim_dir == s1_r.taken);
    end
    bim_new = sat_move(bim_cur, s1_r.taken);
    gsh_new = sat_move(gsh_cur, s1_r.taken);
    ok      = (final_dir == s1_r.taken);
    hit_nxt = hit_r + HIT_W'(ok);
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      bim_mem[clr_idx_r] <= BIM_RST_VAL;
      gsh_mem[clr_idx_r] <= GSH_RST_VAL;
      cho_mem[clr_idx_r] <= CHO_RST_VAL;
    end else if (s1_fire) begin
      bim_mem[s1_r.bi] <= bim_new;
      gsh_mem[s1_r.gi] <= gsh_new;
      cho_mem[s1_r.bi] <= cho_new;
    end
    if (in_acc) begin
      rd_bim_r <= bim_mem[in_bi];
      rd_gsh_r <= gsh_mem[in_gi];
      rd_cho_r <= cho_mem[in_bi];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r.bi    <= in_bi;
      s1_r.gi    <= in_gi;
      s1_r.taken <= in_taken;
      s1_r.fwd   <= s1_fire;
    end
    if (s1_fire) begin
      wb_bi_r     <= s1_r.bi;
      wb_gi_r     <= s1_r.gi;
      wb_bim_r    <= bim_new;
      wb_gsh_r    <= gsh_new;
      wb_cho_r    <= cho_new;
      out_tdata_r <= OUT_TDATA_W'({hit_nxt, sel_bim, ok, final_dir});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
      s1_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      hist_r     <= '0;
      hit_r      <= '0;
    end else begin
      if (clr_busy_r) begin
        clr_idx_r <= clr_idx_r + idx_t'(1);
        if (clr_idx_r == idx_t'(TABLE_ENTRIES - 1)) clr_busy_r <= 1'b0;
      end
      if (in_acc) begin
        hist_r <= hist_nxt;
      end
      if (in_acc) begin
        s1_vld_r <= 1'b1;
      end else if (s1_fire) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_fire) begin
        hit_r     <= hit_nxt;
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_tdata_r;

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !in_tready)
    else $error("request accepted during the clearing pass");

  a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> hit_r == $past(hit_r) + HIT_W'($past(ok)))
    else $error("hit count did not follow the prediction outcome");

  a_agree_pred: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && bim_dir == gsh_dir) |-> (final_dir == bim_dir && cho_new == cho_cur))
    else $error("chooser acted although both predictors agreed");

  a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && !s1_adv) |=> (s1_vld_r && $stable(s1_r)))
    else $error("middle stage lost its request during an output stall");

endmodule

### tb/tbp_outcome_monitor.sv
// Watches both channels of the branch predictor core, predicts every result and compares it.
`timescale 1ns / 100ps

module tbp_outcome_monitor
  import tbp_pkg::*;
#(
  parameter int TABLE_ENTRIES = 2048,
  parameter int HISTORY_BITS  = 11
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // branch_address[31:0], taken[32], zero pad
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,  // predicted_taken[0], prediction_correct[1],
                                             // chose_bimodal[2], correct_total[34:3], zero pad
  output int                     fail_count,
  output int                     pending_count
);

  typedef struct packed {
    logic [OUT_TDATA_W-OUT_FIELD_W-1:0] pad;
    logic [HIT_W-1:0]                   correct_total;
    logic                               chose_bimodal;
    logic                               prediction_correct;
    logic                               predicted_taken;
  } branch_verdict_t;

  ctr_t                    bim_tbl [TABLE_ENTRIES];
  ctr_t                    gsh_tbl [TABLE_ENTRIES];
  ctr_t                    cho_tbl [TABLE_ENTRIES];
  logic [HISTORY_BITS-1:0] history;
  logic [HIT_W-1:0]        hits;
  branch_verdict_t         awaited_verdicts[$];

  function automatic ctr_t nudge_counter(ctr_t c, logic up);
    if (up) return (c == 2'b11) ? c : ctr_t'(c + 2'b01);
    return (c == 2'b00) ? c : ctr_t'(c - 2'b01);
  endfunction

  function automatic branch_verdict_t predict_branch(logic [ADDR_W-1:0] addr, logic taken);
    int unsigned     bi;
    int unsigned     gi;
    int unsigned     hist_ext;
    logic            bim_dir;
    logic            gsh_dir;
    logic            use_bim;
    logic            final_dir;
    branch_verdict_t v;
    hist_ext = history;
    bi = addr % TABLE_ENTRIES;
    gi = (addr ^ hist_ext) % TABLE_ENTRIES;
    bim_dir = bim_tbl[bi][1];
    gsh_dir = gsh_tbl[gi][1];
    use_bim = cho_tbl[bi][1];
    if (bim_dir == gsh_dir) begin
      final_dir = bim_dir;
    end else begin
      final_dir = use_bim ? bim_dir : gsh_dir;
      cho_tbl[bi] = nudge_counter(cho_tbl[bi], bim_dir == taken);
    end
    bim_tbl[bi] = nudge_counter(bim_tbl[bi], taken);
    gsh_tbl[gi] = nudge_counter(gsh_tbl[gi], taken);
    history = HISTORY_BITS'({history, taken});
    if (final_dir == taken) hits = hits + 1;
    v = '0;
    v.predicted_taken    = final_dir;
    v.prediction_correct = (final_dir == taken);
    v.chose_bimodal      = use_bim;
    v.correct_total      = hits;
    return v;
  endfunction

  function automatic int field_mismatch(string name, logic [HIT_W-1:0] want,
                                        logic [HIT_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    branch_verdict_t want;
    branch_verdict_t got;
    int              bad;
    if (!rst_n) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        bim_tbl[i] = 2'b11;
        gsh_tbl[i] = 2'b11;
        cho_tbl[i] = 2'b00;
      end
      history = '0;
      hits = '0;
      awaited_verdicts.delete();
      fail_count = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = branch_verdict_t'(out_tdata);
        if (awaited_verdicts.size() == 0) begin
          $error("result with no request waiting: out_tdata %h", out_tdata);
          fail_count++;
        end else begin
          want = awaited_verdicts.pop_front();
          bad = 0;
          bad += field_mismatch("predicted_taken", want.predicted_taken, got.predicted_taken);
          bad += field_mismatch("prediction_correct", want.prediction_correct,
                                got.prediction_correct);
          bad += field_mismatch("chose_bimodal", want.chose_bimodal, got.chose_bimodal);
          bad += field_mismatch("correct_total", want.correct_total, got.correct_total);
          bad += field_mismatch("pad", want.pad, got.pad);
          if (bad != 0) fail_count++;
        end
      end
      if (in_tvalid && in_tready) begin
        awaited_verdicts.insert(awaited_verdicts.size(),
                                predict_branch(in_tdata[ADDR_W-1:0], in_tdata[ADDR_W]));
      end
    end
    pending_count = awaited_verdicts.size();
  end

endmodule

### tb/tb_tournament_branch_predictor_core.sv
// Stimulus, handshake pacing and verdict for the tournament branch predictor core.
`timescale 1ns / 100ps

module tb_tournament_branch_predictor_core;
  import tbp_pkg::*;

  localparam int TABLE_ENTRIES = 2048;
  localparam int HISTORY_BITS  = 11;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 170;
  localparam int SITE_COUNT    = 16;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int monitor_fails;
  int monitor_pending;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_reqs = 0;
  int holds_done = 0;
  int cycle_count = 0;

  logic [ADDR_W-1:0] site_addr   [SITE_COUNT];
  int                site_period [SITE_COUNT];
  logic              site_flip   [SITE_COUNT];
  int                site_trip   [SITE_COUNT];

  always #10 clk = ~clk;

  tournament_branch_predictor_core #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .HISTORY_BITS (HISTORY_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  tbp_outcome_monitor #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .HISTORY_BITS (HISTORY_BITS)
  ) outcome_mon (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .fail_count   (monitor_fails),
    .pending_count(monitor_pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** tournament_branch_predictor_core: FAILED **");
      $finish;
    end
  end

  initial begin
    out_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  task automatic send_branch(input logic [ADDR_W-1:0] addr, input logic taken);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W-ADDR_W-1){1'b0}}, taken, addr};
    do @(posedge clk); while (!in_tready);
  endtask

  // Most requests replay loop-like branch sites so the tables and history train.
  task automatic random_branch(output logic [ADDR_W-1:0] addr, output logic taken);
    int pick;
    int k;
    pick = $urandom_range(99);
    k = $urandom_range(SITE_COUNT - 1);
    if (pick < 60) begin
      addr = site_addr[k];
      site_trip[k]++;
      taken = ((site_trip[k] % site_period[k]) != 0) ^ site_flip[k];
    end else if (pick < 85) begin
      addr = site_addr[k];
      taken = 1'($urandom_range(1));
    end else begin
      addr = $urandom;
      taken = 1'($urandom_range(1));
    end
  endtask

  task automatic run_phase(input int count, input int tx_pct, input int rx_pct);
    logic [ADDR_W-1:0] addr;
    logic              taken;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    for (int n = 0; n < count; n++) begin
      random_branch(addr, taken);
      send_branch(addr, taken);
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    for (int k = 0; k < SITE_COUNT; k++) begin
      site_addr[k] = $urandom;
      if (k < SITE_COUNT / 2) site_addr[k][10:0] = 11'($urandom_range(7));
      site_period[k] = $urandom_range(9, 2);
      site_flip[k]   = 1'($urandom_range(1));
      site_trip[k]   = 0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Saturation at both ends, aliasing entries and outcome flips that split the two predictors.
    repeat (3) send_branch(32'h0000_0000, 1'b0);
    repeat (2) send_branch(32'hFFFF_FFFF, 1'b1);
    send_branch(32'h0000_0800, 1'b1);
    send_branch(32'h8000_0000, 1'b0);
    send_branch(32'h7FFF_FFFF, 1'b1);
    for (int i = 0; i < 12; i++) send_branch(32'h0000_0001, i[0]);
    send_branch(32'hFFFF_F800, 1'b0);
    send_branch(32'hAAAA_AAAA, 1'b1);
    send_branch(32'h5555_5555, 1'b0);

    run_phase(PHASE_ITEMS, 0, 0);
    run_phase(PHASE_ITEMS, 53, 0);
    run_phase(PHASE_ITEMS, 0, 53);
    run_phase(PHASE_ITEMS, 29, 29);
    hold_reqs++;
    run_phase(60, 0, 0);
    run_phase(PHASE_ITEMS, 0, 0);
    in_tvalid <= 1'b0;

    while (monitor_pending != 0 || hold_reqs != holds_done) @(posedge clk);
    repeat (8) @(posedge clk);
    if (monitor_fails == 0) begin
      $display("** tournament_branch_predictor_core: PASSED **");
    end else begin
      $display("** tournament_branch_predictor_core: FAILED **");
    end
    $finish;
  end

endmodule
